>>> rtl/core/tda_pkg.sv
package tda_pkg;

  localparam int unsigned Day      = 86400;
  localparam int unsigned Hour     = 3600;
  localparam int unsigned Minute   = 60;
  localparam int          TimeW    = 17;
  localparam int          AmtW     = 20;
  localparam int          NumCells = AmtW;

  // Reciprocal constants for splitting a time of day into fields.
  localparam int          HourShift = 30;
  localparam int unsigned HourRecip = 298262;
  localparam int          MinShift  = 22;
  localparam int unsigned MinRecip  = 69906;

  localparam logic [2:0] OP_ADD_TIME = 3'd0;
  localparam logic [2:0] OP_ADD_SECS = 3'd1;
  localparam logic [2:0] OP_SUB_TIME = 3'd2;
  localparam logic [2:0] OP_SUB_SECS = 3'd3;
  localparam logic [2:0] OP_MUL      = 3'd4;
  localparam logic [2:0] OP_DIV      = 3'd5;
  localparam logic [2:0] OP_CMP      = 3'd6;

  typedef struct packed {
    logic [2:0]       op;
    logic [TimeW-1:0] ta;
    logic [TimeW-1:0] tb;
    logic [AmtW-1:0]  dvs;   // divisor, unchanged along the row
    logic [TimeW-1:0] mc;    // multiplicand of the modular product
    logic [AmtW-1:0]  mq;    // multiplier, consumed from the top bit
    logic [TimeW-1:0] acc;   // modular product so far
    logic [AmtW-1:0]  dnd;   // dividend, consumed from the top bit
    logic [AmtW-1:0]  rem;
    logic [AmtW-1:0]  quo;
  } tda_item_t;

endpackage

>>> rtl/core/tda_front.sv
module tda_front import tda_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_ok,
  input  logic [2:0]      op,
  input  logic [4:0]      a_hours,
  input  logic [5:0]      a_minutes,
  input  logic [5:0]      a_seconds,
  input  logic [4:0]      b_hours,
  input  logic [5:0]      b_minutes,
  input  logic [5:0]      b_seconds,
  input  logic [AmtW-1:0] amount,
  output logic            item_ok,
  output tda_item_t       item
);

  logic [TimeW:0]   raw_a, raw_b;
  logic [TimeW-1:0] ta, tb;
  tda_item_t        item_next;

  // Out-of-range fields stay below two days, so one subtraction reduces them.
  always_comb begin
    raw_a = 18'(a_hours) * 18'(Hour) + 18'(a_minutes) * 18'(Minute) + 18'(a_seconds);
    raw_b = 18'(b_hours) * 18'(Hour) + 18'(b_minutes) * 18'(Minute) + 18'(b_seconds);
    ta = (raw_a >= 18'(Day)) ? 17'(raw_a - 18'(Day)) : raw_a[TimeW-1:0];
    tb = (raw_b >= 18'(Day)) ? 17'(raw_b - 18'(Day)) : raw_b[TimeW-1:0];
    item_next.op  = op;
    item_next.ta  = ta;
    item_next.tb  = tb;
    item_next.dvs = amount;
    // Add and subtract of seconds reduce the amount as amount times one.
    item_next.mc  = (op == OP_MUL) ? ta : 17'd1;
    item_next.mq  = amount;
    item_next.acc = '0;
    item_next.dnd = AmtW'(ta);
    item_next.rem = '0;
    item_next.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_ok <= 1'b0;
    end else if (en) begin
      item_ok <= in_ok;
    end
    if (en) begin
      item <= item_next;
    end
  end

endmodule

>>> rtl/core/tda_cell.sv
module tda_cell import tda_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      prev_ok,
  input  tda_item_t prev,
  output logic      item_ok,
  output tda_item_t item
);

  logic [TimeW+1:0] m2;
  logic [AmtW:0]    r;
  logic             ge;
  tda_item_t        item_next;

  // One multiplier bit of a modular product and one quotient bit of a division.
  always_comb begin
    item_next = prev;
    m2 = {1'b0, prev.acc, 1'b0} + (prev.mq[AmtW-1] ? 19'(prev.mc) : 19'd0);
    if (m2 >= 19'(2 * Day)) begin
      item_next.acc = 17'(m2 - 19'(2 * Day));
    end else if (m2 >= 19'(Day)) begin
      item_next.acc = 17'(m2 - 19'(Day));
    end else begin
      item_next.acc = m2[TimeW-1:0];
    end
    item_next.mq = {prev.mq[AmtW-2:0], 1'b0};
    r  = {prev.rem, prev.dnd[AmtW-1]};
    ge = r >= {1'b0, prev.dvs};
    item_next.rem = ge ? 20'(r - {1'b0, prev.dvs}) : r[AmtW-1:0];
    item_next.quo = {prev.quo[AmtW-2:0], ge};
    item_next.dnd = {prev.dnd[AmtW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_ok <= 1'b0;
    end else if (en) begin
      item_ok <= prev_ok;
    end
    if (en) begin
      item <= item_next;
    end
  end

endmodule

>>> rtl/core/tda_back.sv
module tda_back import tda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       prev_ok,
  input  tda_item_t  prev,
  output logic       valid,
  output logic [4:0] res_hours,
  output logic [5:0] res_minutes,
  output logic [5:0] res_seconds,
  output logic       is_less,
  output logic       is_equal,
  output logic       is_greater,
  output logic       div_error
);

  // Stage 1: result seconds and flags. Stage 2: hours. Stage 3: remainder.
  // Stage 4: minutes and seconds.
  logic [TimeW:0]   sum;
  logic [TimeW-1:0] res_next, res1, res2;
  logic [3:0]       flags_next, flags1, flags2, flags3;
  logic [4:0]       hr2, hr3;
  logic [11:0]      r3;
  logic [33:0]      mprod;
  logic [5:0]       mn;
  logic [3:0]       ok;

  always_comb begin
    res_next   = '0;
    flags_next = '0;
    sum        = '0;
    case (prev.op)
      OP_ADD_TIME: sum = 18'(prev.ta) + 18'(prev.tb);
      OP_ADD_SECS: sum = 18'(prev.ta) + 18'(prev.acc);
      OP_SUB_TIME: sum = 18'(prev.ta) + 18'(Day) - 18'(prev.tb);
      OP_SUB_SECS: sum = 18'(prev.ta) + 18'(Day) - 18'(prev.acc);
      OP_MUL:      sum = 18'(prev.acc);
      OP_DIV: begin
        if (prev.dvs == '0) begin
          flags_next[0] = 1'b1;
        end else begin
          sum = 18'(prev.quo[TimeW-1:0]);
        end
      end
      OP_CMP: begin
        flags_next[3] = prev.ta < prev.tb;
        flags_next[2] = prev.ta == prev.tb;
        flags_next[1] = prev.ta > prev.tb;
      end
      default: sum = '0;
    endcase
    res_next = (sum >= 18'(Day)) ? 17'(sum - 18'(Day)) : sum[TimeW-1:0];
    mprod = 34'(r3) * 34'(MinRecip);
    mn    = 6'(mprod >> MinShift);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ok <= '0;
    end else if (en) begin
      ok <= {ok[2:0], prev_ok};
    end
    if (en) begin
      res1   <= res_next;
      flags1 <= flags_next;
      res2   <= res1;
      flags2 <= flags1;
      hr2    <= 5'(48'(res1) * 48'(HourRecip) >> HourShift);
      hr3    <= hr2;
      flags3 <= flags2;
      r3     <= 12'(res2 - 17'(hr2) * 17'(Hour));
      res_hours   <= hr3;
      res_minutes <= mn;
      res_seconds <= 6'(r3 - 12'(mn) * 12'(Minute));
      {is_less, is_equal, is_greater, div_error} <= flags3;
    end
  end

  assign valid = ok[3];

endmodule

>>> rtl/core/time_of_day_alu.sv
// Time-of-day arithmetic unit, modulo one day.
// Input channel: valid, stall and the fields op, a_*, b_* and amount. A
// transfer takes place at a rising edge with valid high and stall low.
// Output channel: valid, out_stall and the result fields; one result leaves
// for each input transfer, in order.
// Operations: add or subtract a time or a number of seconds, multiply or
// divide by amount, and compare. Divide by zero returns 00:00:00 with
// div_error set; compare returns zero time and one flag.
// Path of a result from its input transfer: the input register
// loads at the transfer edge, then a row of 20 cells that each take one
// multiplier bit of the modular product and one quotient bit of the
// division, one result stage and three stages that split seconds into
// hours, minutes and seconds. Throughput is one transfer per cycle while
// the output is not stalled. When the receiver stalls with a result
// waiting, the whole pipeline holds and the input stall rises in the
// same cycle. Reset empties the pipeline; no result is pending afterward.
module time_of_day_alu import tda_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  output logic            stall,
  input  logic [2:0]      op,
  input  logic [4:0]      a_hours,
  input  logic [5:0]      a_minutes,
  input  logic [5:0]      a_seconds,
  input  logic [4:0]      b_hours,
  input  logic [5:0]      b_minutes,
  input  logic [5:0]      b_seconds,
  input  logic [AmtW-1:0] amount,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [4:0]      res_hours,
  output logic [5:0]      res_minutes,
  output logic [5:0]      res_seconds,
  output logic            is_less,
  output logic            is_equal,
  output logic            is_greater,
  output logic            div_error
);

  logic      en;
  logic      ok [NumCells+1];
  tda_item_t row [NumCells+1];

  assign en    = !(out_valid && out_stall);
  assign stall = !en;

  tda_front u_front (
    .clk, .rst, .en, .in_ok(valid), .op, .a_hours, .a_minutes, .a_seconds,
    .b_hours, .b_minutes, .b_seconds, .amount, .item_ok(ok[0]), .item(row[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    tda_cell u_cell (
      .clk, .rst, .en, .prev_ok(ok[i]), .prev(row[i]),
      .item_ok(ok[i+1]), .item(row[i+1])
    );
  end

  tda_back u_back (
    .clk, .rst, .en, .prev_ok(ok[NumCells]), .prev(row[NumCells]),
    .valid(out_valid), .res_hours, .res_minutes, .res_seconds,
    .is_less, .is_equal, .is_greater, .div_error
  );

endmodule

>>> rtl/core/tda_checker.sv
module tda_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] res_hours,
  input logic [5:0] res_minutes,
  input logic [5:0] res_seconds,
  input logic       is_less,
  input logic       is_equal,
  input logic       is_greater,
  input logic       div_error
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_seconds) && $stable(is_less))
    else $error("stalled result changed");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({is_less, is_equal, is_greater, div_error}) <= 1)
    else $error("more than one flag set");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (is_less || is_equal || is_greater || div_error)
      |-> res_hours == 5'd0 && res_minutes == 6'd0 && res_seconds == 6'd0)
    else $error("flagged result carries a time");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res_hours <= 5'd23 && res_minutes <= 6'd59 && res_seconds <= 6'd59)
    else $error("result field out of range");

endmodule

bind time_of_day_alu tda_checker u_tda_checker (
  .clk, .rst, .out_valid, .out_stall, .res_hours, .res_minutes, .res_seconds,
  .is_less, .is_equal, .is_greater, .div_error
);

>>> sim/time_of_day_alu_tb.sv
`timescale 1ns / 100ps

module time_of_day_alu_tb;
  import tda_pkg::*;

  typedef struct packed {
    logic [2:0]      op;
    logic [4:0]      a_hours;
    logic [5:0]      a_minutes;
    logic [5:0]      a_seconds;
    logic [4:0]      b_hours;
    logic [5:0]      b_minutes;
    logic [5:0]      b_seconds;
    logic [AmtW-1:0] amount;
  } tod_req_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       lt;
    logic       eq;
    logic       gt;
    logic       derr;
  } tod_res_t;

  localparam int unsigned OP_UNUSED  = 7;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Drain      = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic stall;
  logic [2:0] op = '0;
  logic [4:0] a_hours = '0;
  logic [5:0] a_minutes = '0;
  logic [5:0] a_seconds = '0;
  logic [4:0] b_hours = '0;
  logic [5:0] b_minutes = '0;
  logic [5:0] b_seconds = '0;
  logic [AmtW-1:0] amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] res_hours;
  logic [5:0] res_minutes;
  logic [5:0] res_seconds;
  logic is_less, is_equal, is_greater, div_error;

  tod_req_t pending_reqs[$];
  tod_res_t expected_results[$];
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned op_count[8];
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_off = 0;
  logic long_hold_done = 1'b0;
  logic pause_sender = 1'b0;

  always #10 clk = ~clk;

  time_of_day_alu u_top (
    .clk, .rst, .valid, .stall, .op, .a_hours, .a_minutes, .a_seconds,
    .b_hours, .b_minutes, .b_seconds, .amount, .out_valid, .out_stall,
    .res_hours, .res_minutes, .res_seconds, .is_less, .is_equal,
    .is_greater, .div_error
  );

  function automatic logic [TimeW-1:0] day_secs(logic [4:0] h, logic [5:0] m,
                                                logic [5:0] s);
    int unsigned t;
    t = h * Hour + m * Minute + s;
    return TimeW'(t % Day);
  endfunction

  function automatic tod_res_t tod_compute(tod_req_t r);
    tod_res_t res;
    int unsigned ta, tb, amt, secs;
    longint unsigned prod;
    res = '0;
    secs = 0;
    ta = 32'(day_secs(r.a_hours, r.a_minutes, r.a_seconds));
    tb = 32'(day_secs(r.b_hours, r.b_minutes, r.b_seconds));
    amt = 32'(r.amount);
    case (r.op)
      OP_ADD_TIME: secs = (ta + tb) % Day;
      OP_ADD_SECS: secs = (ta + amt % Day) % Day;
      OP_SUB_TIME: secs = (ta + Day - tb) % Day;
      OP_SUB_SECS: secs = (ta + Day - amt % Day) % Day;
      OP_MUL: begin
        prod = longint'(ta) * longint'(amt);
        secs = 32'(prod % Day);
      end
      OP_DIV: begin
        if (amt == 0) res.derr = 1'b1;
        else secs = ta / amt;
      end
      OP_CMP: begin
        res.lt = ta < tb;
        res.eq = ta == tb;
        res.gt = ta > tb;
      end
      default: secs = 0;
    endcase
    res.hours = 5'(secs / Hour);
    res.minutes = 6'((secs % Hour) / Minute);
    res.seconds = 6'(secs % Minute);
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch at result %0d: %s got %0d expected %0d",
             checked_count, field, got, want);
    error_count++;
  endtask

  // A legal time most of the time; raw field values now and then.
  function automatic tod_req_t random_req();
    tod_req_t r;
    r = '0;
    r.op = ($urandom_range(0, 19) == 0) ? 3'(OP_UNUSED) : 3'($urandom_range(0, 6));
    if ($urandom_range(0, 7) == 0) begin
      {r.a_hours, r.a_minutes, r.a_seconds} = 17'($urandom);
      {r.b_hours, r.b_minutes, r.b_seconds} = 17'($urandom);
    end else begin
      r.a_hours = 5'($urandom_range(0, 23));
      r.a_minutes = 6'($urandom_range(0, 59));
      r.a_seconds = 6'($urandom_range(0, 59));
      if ($urandom_range(0, 3) == 0) begin
        {r.b_hours, r.b_minutes, r.b_seconds} = {r.a_hours, r.a_minutes, r.a_seconds};
      end else begin
        r.b_hours = 5'($urandom_range(0, 23));
        r.b_minutes = 6'($urandom_range(0, 59));
        r.b_seconds = 6'($urandom_range(0, 59));
      end
    end
    case ($urandom_range(0, 4))
      0: r.amount = AmtW'($urandom_range(0, 3));
      1: r.amount = AmtW'($urandom_range(0, 200));
      2: r.amount = AmtW'($urandom_range(86390, 86410));
      default: r.amount = AmtW'($urandom);
    endcase
    return r;
  endfunction

  function automatic tod_req_t make_req(logic [2:0] o, logic [4:0] ah, logic [5:0] am,
                                        logic [5:0] as_, logic [4:0] bh,
                                        logic [5:0] bm, logic [5:0] bs,
                                        logic [AmtW-1:0] amt);
    tod_req_t r;
    r = '{o, ah, am, as_, bh, bm, bs, amt};
    return r;
  endfunction

  // Driver: a payload only changes after a transfer or while valid is low.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (valid && !stall) sent_count <= sent_count + 1;
      if (!(valid && stall)) begin
        if (pending_reqs.size() != 0 && !pause_sender &&
            (burst_left != 0 || gap_left == 0)) begin
          tod_req_t r;
          r = pending_reqs.pop_front();
          valid <= 1'b1;
          {op, a_hours, a_minutes, a_seconds, b_hours, b_minutes, b_seconds,
           amount} <= r;
          expected_results.push_back(tod_compute(r));
          op_count[r.op]++;
          if (burst_left != 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off counted here.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_off != 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else if (!long_hold_done && sent_count >= 300) begin
        hold_off <= 80;
        long_hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (cycle_count[9:8] == 2'd0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  always @(posedge clk) begin
    tod_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result %0d with no transfer waiting", checked_count);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_hours !== want.hours) report_mismatch("res_hours", res_hours, want.hours);
        if (res_minutes !== want.minutes)
          report_mismatch("res_minutes", res_minutes, want.minutes);
        if (res_seconds !== want.seconds)
          report_mismatch("res_seconds", res_seconds, want.seconds);
        if (is_less !== want.lt) report_mismatch("is_less", is_less, want.lt);
        if (is_equal !== want.eq) report_mismatch("is_equal", is_equal, want.eq);
        if (is_greater !== want.gt) report_mismatch("is_greater", is_greater, want.gt);
        if (div_error !== want.derr) report_mismatch("div_error", div_error, want.derr);
      end
      checked_count <= checked_count + 1;
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes, every op, wrap, divide by zero, raw fields.
    pending_reqs.push_back(make_req(OP_ADD_TIME, 23, 59, 59, 0, 0, 1, 0));
    pending_reqs.push_back(make_req(OP_ADD_TIME, 23, 59, 59, 23, 59, 59, 0));
    pending_reqs.push_back(make_req(OP_ADD_SECS, 23, 59, 59, 0, 0, 0, '1));
    pending_reqs.push_back(make_req(OP_ADD_SECS, 0, 0, 0, 0, 0, 0, 86400));
    pending_reqs.push_back(make_req(OP_SUB_TIME, 0, 0, 0, 0, 0, 1, 0));
    pending_reqs.push_back(make_req(OP_SUB_TIME, 12, 30, 0, 12, 30, 0, 0));
    pending_reqs.push_back(make_req(OP_SUB_SECS, 0, 0, 0, 0, 0, 0, '1));
    pending_reqs.push_back(make_req(OP_SUB_SECS, 1, 0, 0, 0, 0, 0, 3601));
    pending_reqs.push_back(make_req(OP_MUL, 23, 59, 59, 0, 0, 0, '1));
    pending_reqs.push_back(make_req(OP_MUL, 5, 6, 7, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_MUL, 31, 63, 63, 0, 0, 0, 2));
    pending_reqs.push_back(make_req(OP_DIV, 23, 59, 59, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_DIV, 23, 59, 59, 0, 0, 0, 1));
    pending_reqs.push_back(make_req(OP_DIV, 23, 59, 59, 0, 0, 0, '1));
    pending_reqs.push_back(make_req(OP_DIV, 10, 0, 0, 0, 0, 0, 7));
    pending_reqs.push_back(make_req(OP_CMP, 1, 2, 3, 1, 2, 4, 0));
    pending_reqs.push_back(make_req(OP_CMP, 1, 2, 3, 1, 2, 3, 0));
    pending_reqs.push_back(make_req(OP_CMP, 23, 59, 59, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_CMP, 24, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_ADD_TIME, 31, 63, 63, 31, 63, 63, 0));
    pending_reqs.push_back(make_req(3'(OP_UNUSED), 31, 63, 63, 31, 63, 63, '1));
    for (int i = 0; i < 420; i++) pending_reqs.push_back(random_req());
    wait (pending_reqs.size() == 0 && expected_results.size() == 0);
    // Sender pause while the next requests are queued, after the pipeline has drained completely.
    pause_sender = 1'b1;
    for (int i = 0; i < 410; i++) pending_reqs.push_back(random_req());
    repeat (30) @(posedge clk);
    pause_sender = 1'b0;
    wait (pending_reqs.size() == 0 && expected_results.size() == 0);
    repeat (Drain) @(posedge clk);
    $display("checked %0d results over ops 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             checked_count, op_count[0], op_count[1], op_count[2], op_count[3],
             op_count[4], op_count[5], op_count[6], op_count[7]);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
